// File: hw/rtl/g2e_pkg.sv
// Shared constants, register codes and a helper function for the geodetic to ECEF core.
package g2e_pkg;

    localparam int CORDIC_STAGES_DEF = 28;
    localparam int MUL_LAT           = 4;

    localparam logic signed [63:0] ONE_Q61   = 64'sh2000_0000_0000_0000;
    localparam logic signed [63:0] THREE_Q61 = 64'sh6000_0000_0000_0000;
    localparam logic signed [63:0] E2_Q61    = 64'sd15436189301287365;
    localparam logic signed [63:0] OMS_E2_Q61 = ONE_Q61 - E2_Q61;
    localparam logic signed [63:0] KINV_Q61  = 64'sd1400229935014568078;
    localparam logic signed [63:0] PI4_Q61   = 64'sh1921_FB54_442D_1846;
    localparam logic [63:0]        PI_Q61    = 64'h3243_F6A8_885A_308D;
    localparam logic signed [63:0] DEG_Q61   = $signed(PI_Q61 / 64'd90);

    localparam logic signed [33:0] DEG90  = 34'sd754974720;
    localparam logic signed [33:0] DEG180 = 34'sd1509949440;
    localparam logic signed [33:0] DEG360 = 34'sd3019898880;

    localparam logic signed [64:0] OUT_MAX = 65'sd140737488355327;

    localparam logic [39:0] EARTH_RADIUS_RST = 40'd1632803072;

    typedef enum logic [1:0] {
        REG_EARTH_RADIUS = 2'd0,
        REG_CENTRE_X     = 2'd1,
        REG_CENTRE_Y     = 2'd2,
        REG_CENTRE_Z     = 2'd3
    } cfg_reg_t;

    // atan(2^-i) in Q61 as a truncated alternating series
    function automatic logic signed [63:0] atan_q61(input int unsigned i);
        logic signed [63:0] sum;
        logic [63:0]        t;
        int unsigned        k;
        int unsigned        m;
        int unsigned        den;
        begin
            sum = '0;
            if (i == 0)
            begin
                sum = PI4_Q61;
            end
            else
            begin
                for (k = 0; k < 31; k++)
                begin
                    m   = i * (2 * k + 1);
                    den = 2 * k + 1;
                    if (m <= 61)
                    begin
                        t = (64'd1 << (61 - m)) / 64'(den);
                        if (k[0])
                            sum = sum - $signed(t);
                        else
                            sum = sum + $signed(t);
                    end
                end
            end
            return sum;
        end
    endfunction

endpackage

// File: hw/rtl/g2e_delay.sv
// Enabled shift line that delays a word through D register stages.
module g2e_delay #(
    parameter int W = 64,
    parameter int D = 4
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] tap_reg [0:D-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= d;
            for (int i = 1; i < D; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[D-1];

endmodule

// File: hw/rtl/g2e_mul.sv
// Four-stage 64x64 signed multiplier with round-half-away shift and saturation.
module g2e_mul #(
    parameter int SH = 61
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output logic signed [63:0] p
);

    localparam logic [127:0] HALF = 128'd1 << (SH - 1);

    logic         neg1_reg, neg2_reg, neg3_reg;
    logic [63:0]  ma_reg, mb_reg;
    logic [63:0]  p00_reg, p01_reg, p10_reg, p11_reg;
    logic [127:0] sum_reg;
    logic signed [63:0] p_reg;
    logic [63:0]  mag;
    logic         sat;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg <= a[63] ^ b[63];
            ma_reg   <= a[63] ? (~$unsigned(a) + 64'd1) : $unsigned(a);
            mb_reg   <= b[63] ? (~$unsigned(b) + 64'd1) : $unsigned(b);

            neg2_reg <= neg1_reg;
            p00_reg  <= ma_reg[31:0]  * mb_reg[31:0];
            p01_reg  <= ma_reg[31:0]  * mb_reg[63:32];
            p10_reg  <= ma_reg[63:32] * mb_reg[31:0];
            p11_reg  <= ma_reg[63:32] * mb_reg[63:32];

            neg3_reg <= neg2_reg;
            sum_reg  <= {64'd0, p00_reg} + {32'd0, p01_reg, 32'd0}
                      + {32'd0, p10_reg, 32'd0} + {p11_reg, 64'd0} + HALF;

            p_reg    <= neg3_reg ? -$signed(mag) : $signed(mag);
        end
    end

    always_comb
    begin
        sat = |sum_reg[127:63+SH];
        mag = sat ? 64'h7FFF_FFFF_FFFF_FFFF : sum_reg[SH+63:SH];
    end

    assign p = p_reg;

endmodule

// File: hw/rtl/g2e_cordic.sv
// Pipelined rotation-mode CORDIC giving sine and cosine of a Q61 angle.
module g2e_cordic #(
    parameter int STAGES = g2e_pkg::CORDIC_STAGES_DEF
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [63:0] angle,
    input  logic               flip,
    output logic signed [63:0] sin_q,
    output logic signed [63:0] cos_q
);

    logic signed [63:0] x_reg [0:STAGES];
    logic signed [63:0] y_reg [0:STAGES];
    logic signed [63:0] z_reg [0:STAGES];
    logic               flip_reg [0:STAGES];
    logic signed [63:0] sin_reg, cos_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= g2e_pkg::KINV_Q61;
            y_reg[0]    <= '0;
            z_reg[0]    <= angle;
            flip_reg[0] <= flip;
            sin_reg     <= y_reg[STAGES];
            cos_reg     <= flip_reg[STAGES] ? -x_reg[STAGES] : x_reg[STAGES];
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        localparam logic signed [63:0] ANG = g2e_pkg::atan_q61(i);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                flip_reg[i+1] <= flip_reg[i];
                if (!z_reg[i][63])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ANG;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ANG;
                end
            end
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

// File: hw/rtl/geodetic_to_ecef_core.sv
// Top level: WGS84 geodetic to earth-centred, re-centred coordinates.
//
// One word in, one word out, one word per cycle sustained unless m_tready stalls
// the pipeline. The path runs through the two CORDICs, the four Newton steps
// for 1/sqrt(1 - e2 sin^2 lat) and the chain of four-stage multipliers.
// Inputs are degrees * 2^23, outputs are 1/256 m with the configured centre
// subtracted and saturated to +-(2^47 - 1). Write the configuration registers
// only while no word is in flight.
module geodetic_to_ecef_core #(
    parameter int CORDIC_STAGES = g2e_pkg::CORDIC_STAGES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // latitude[30:0], longitude[62:31], altitude[94:63], pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // pos_x[47:0], pos_y[95:48], pos_z[143:96]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [47:0]  cfg_data
);

    localparam int ML      = g2e_pkg::MUL_LAT;
    localparam int T_Z     = ML;
    localparam int T_C     = T_Z + CORDIC_STAGES + 2;
    localparam int T_W     = T_C + 2 * ML + 1;
    localparam int NEWTON  = 3 * ML + 1;
    localparam int T_Y     = T_W + 4 * NEWTON;
    localparam int T_N     = T_Y + ML;
    localparam int T_P     = T_N + 1;
    localparam int T_F     = T_P + ML;
    localparam int T_O     = T_F + ML;
    localparam int T_OUT   = T_O + 1;

    logic adv;

    logic [39:0]        radius_reg;
    logic signed [47:0] cx_reg, cy_reg, cz_reg;

    logic [T_OUT:0]     vld_reg;
    logic signed [31:0] lat_reg, lon_reg, alt_reg;
    logic               lat_flip_reg, lon_flip_reg;
    logic [32:0]        lat_fold, lon_fold;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= g2e_pkg::EARTH_RADIUS_RST;
            cx_reg     <= '0;
            cy_reg     <= '0;
            cz_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (g2e_pkg::cfg_reg_t'(cfg_index))
                g2e_pkg::REG_EARTH_RADIUS: radius_reg <= cfg_data[39:0];
                g2e_pkg::REG_CENTRE_X:     cx_reg     <= $signed(cfg_data);
                g2e_pkg::REG_CENTRE_Y:     cy_reg     <= $signed(cfg_data);
                g2e_pkg::REG_CENTRE_Z:     cz_reg     <= $signed(cfg_data);
                default:                   radius_reg <= radius_reg;
            endcase
        end
    end

    function automatic logic [32:0] fold_angle(input logic signed [33:0] a_in);
        logic signed [33:0] a;
        logic               fl;
        begin
            a  = a_in;
            fl = 1'b0;
            if (a > g2e_pkg::DEG180)
                a = a - g2e_pkg::DEG360;
            else if (a < -g2e_pkg::DEG180)
                a = a + g2e_pkg::DEG360;
            if (a > g2e_pkg::DEG90)
            begin
                a  = g2e_pkg::DEG180 - a;
                fl = 1'b1;
            end
            else if (a < -g2e_pkg::DEG90)
            begin
                a  = -g2e_pkg::DEG180 - a;
                fl = 1'b1;
            end
            return {fl, a[31:0]};
        end
    endfunction

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    always_comb
    begin
        lat_fold = fold_angle(34'(signed'(s_tdata[30:0])));
        lon_fold = fold_angle(34'(signed'(s_tdata[62:31])));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[T_OUT-1:0], s_tvalid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lat_reg      <= $signed(lat_fold[31:0]);
            lat_flip_reg <= lat_fold[32];
            lon_reg      <= $signed(lon_fold[31:0]);
            lon_flip_reg <= lon_fold[32];
            alt_reg      <= $signed(s_tdata[94:63]);
        end
    end

    // degrees to radians
    logic signed [63:0] lat_rad, lon_rad;
    logic [1:0]         flip_d;

    g2e_mul #(.SH(23)) u_lat_rad (.clk(clk), .en(adv), .a(64'(lat_reg)),
        .b(g2e_pkg::DEG_Q61), .p(lat_rad));
    g2e_mul #(.SH(23)) u_lon_rad (.clk(clk), .en(adv), .a(64'(lon_reg)),
        .b(g2e_pkg::DEG_Q61), .p(lon_rad));
    g2e_delay #(.W(2), .D(ML)) u_flip_d (.clk(clk), .en(adv),
        .d({lat_flip_reg, lon_flip_reg}), .q(flip_d));

    logic signed [63:0] sl, cl, so, co;

    g2e_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_lat (.clk(clk), .en(adv),
        .angle(lat_rad), .flip(flip_d[1]), .sin_q(sl), .cos_q(cl));
    g2e_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_lon (.clk(clk), .en(adv),
        .angle(lon_rad), .flip(flip_d[0]), .sin_q(so), .cos_q(co));

    // w = 1 - e2 sin^2 lat
    logic signed [63:0] sl_sq, e_sl_sq, w_reg;

    g2e_mul #(.SH(61)) u_sl_sq (.clk(clk), .en(adv), .a(sl), .b(sl), .p(sl_sq));
    g2e_mul #(.SH(61)) u_e_sl (.clk(clk), .en(adv), .a(g2e_pkg::E2_Q61), .b(sl_sq),
        .p(e_sl_sq));

    always_ff @(posedge clk)
    begin
        if (adv)
            w_reg <= g2e_pkg::ONE_Q61 - e_sl_sq;
    end

    // Newton iterations for 1/sqrt(w)
    logic signed [63:0] y_s [0:4];
    logic signed [63:0] w_s [0:4];

    assign y_s[0] = g2e_pkg::ONE_Q61;
    assign w_s[0] = w_reg;

    for (genvar k = 0; k < 4; k++)
    begin : g_newton
        logic signed [63:0] yy, w4, t, y9, d_reg;

        g2e_mul #(.SH(61)) u_yy (.clk(clk), .en(adv), .a(y_s[k]), .b(y_s[k]), .p(yy));
        g2e_delay #(.W(64), .D(ML)) u_w4 (.clk(clk), .en(adv), .d(w_s[k]), .q(w4));
        g2e_mul #(.SH(61)) u_t (.clk(clk), .en(adv), .a(w4), .b(yy), .p(t));

        always_ff @(posedge clk)
        begin
            if (adv)
                d_reg <= g2e_pkg::THREE_Q61 - t;
        end

        g2e_delay #(.W(64), .D(2 * ML + 1)) u_y9 (.clk(clk), .en(adv), .d(y_s[k]), .q(y9));
        g2e_mul #(.SH(62)) u_y (.clk(clk), .en(adv), .a(y9), .b(d_reg), .p(y_s[k+1]));
        g2e_delay #(.W(64), .D(2 * ML + 1)) u_wn (.clk(clk), .en(adv), .d(w4), .q(w_s[k+1]));
    end

    // N, N + h and (1 - e2) N + h
    logic signed [63:0] n_rad, nb;
    logic signed [31:0] alt_n, alt_n4;
    logic signed [63:0] p_reg, zr_reg, cl_p, pc;

    g2e_mul #(.SH(61)) u_n (.clk(clk), .en(adv), .a($signed({24'd0, radius_reg})),
        .b(y_s[4]), .p(n_rad));
    g2e_delay #(.W(32), .D(T_N)) u_alt_n (.clk(clk), .en(adv), .d(alt_reg), .q(alt_n));
    g2e_delay #(.W(32), .D(ML)) u_alt_n4 (.clk(clk), .en(adv), .d(alt_n), .q(alt_n4));
    g2e_mul #(.SH(61)) u_nb (.clk(clk), .en(adv), .a(n_rad), .b(g2e_pkg::OMS_E2_Q61),
        .p(nb));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg  <= n_rad + 64'(alt_n);
            zr_reg <= nb + 64'(alt_n4);
        end
    end

    g2e_delay #(.W(64), .D(T_P - T_C)) u_cl_d (.clk(clk), .en(adv), .d(cl), .q(cl_p));
    g2e_mul #(.SH(61)) u_pc (.clk(clk), .en(adv), .a(p_reg), .b(cl_p), .p(pc));

    // final products
    logic signed [63:0] co_f, so_f, sl_f, x_o, y_o, z_o;

    g2e_delay #(.W(64), .D(T_F - T_C)) u_co_d (.clk(clk), .en(adv), .d(co), .q(co_f));
    g2e_delay #(.W(64), .D(T_F - T_C)) u_so_d (.clk(clk), .en(adv), .d(so), .q(so_f));
    g2e_delay #(.W(64), .D(T_F - T_C)) u_sl_d (.clk(clk), .en(adv), .d(sl), .q(sl_f));

    g2e_mul #(.SH(61)) u_x (.clk(clk), .en(adv), .a(pc), .b(co_f), .p(x_o));
    g2e_mul #(.SH(61)) u_y (.clk(clk), .en(adv), .a(pc), .b(so_f), .p(y_o));
    g2e_mul #(.SH(61)) u_z (.clk(clk), .en(adv), .a(zr_reg), .b(sl_f), .p(z_o));

    function automatic logic [47:0] sat_sub(input logic signed [63:0] v,
                                            input logic signed [47:0] c);
        logic signed [64:0] diff;
        begin
            diff = 65'(v) - 65'(c);
            if (diff > g2e_pkg::OUT_MAX)
                diff = g2e_pkg::OUT_MAX;
            else if (diff < -g2e_pkg::OUT_MAX)
                diff = -g2e_pkg::OUT_MAX;
            return diff[47:0];
        end
    endfunction

    logic [143:0] out_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= {sat_sub(z_o, cz_reg), sat_sub(y_o, cy_reg), sat_sub(x_o, cx_reg)};
    end

    assign m_tdata  = out_reg;
    assign m_tvalid = vld_reg[T_OUT];

endmodule
